// ===== design/sorted_list_insert_delete_macros.svh =====
// assertion macros for the sorted list insert/delete block
// used by the port checker, no other dependencies
`ifndef SORTED_LIST_INSERT_DELETE_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SLI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted list port check failed");

// next-cycle implication, disabled while reset is low
`define SLI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted list port check failed");

`endif

// ===== design/sli_pkg.sv =====
// shared types and constants for the sorted list insert/delete block
// no dependencies
`timescale 1ns / 1ps

package sli_pkg;

    localparam int VALUE_W          = 32;
    localparam int STATUS_W         = 3;
    localparam int POS_W            = 4;
    localparam int COUNT_W          = 5;
    localparam int DEFAULT_CAPACITY = 16;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    // what a cell shows its neighbours
    typedef struct packed {
        logic                      valid;
        logic                      gt;
        logic                      eq;
        logic signed [VALUE_W-1:0] value;
    } sli_link_t;

    // broadcast to every cell
    typedef struct packed {
        logic                      ins_en;
        logic                      del_en;
        logic                      is_del;
        logic signed [VALUE_W-1:0] key;
    } sli_cmd_t;

    // virtual neighbour ahead of the head: always larger, never equal
    localparam sli_link_t HEAD_LINK = '{valid: 1'b1, gt: 1'b1, eq: 1'b0, value: '0};
    // virtual neighbour past the tail: empty
    localparam sli_link_t TAIL_LINK = '{valid: 1'b0, gt: 1'b0, eq: 1'b0, value: '0};

endpackage

// ===== design/sli_cell.sv =====
// one storage cell of the sorted list: compares against the key and shifts
// toward the tail on insert or toward the head on delete; uses sli_pkg
`timescale 1ns / 1ps

module sli_cell import sli_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  sli_cmd_t  cmd,
    input  sli_link_t prev_link,
    input  sli_link_t next_link,
    output sli_link_t link,
    output logic      mark
);

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      le;

    always_comb begin
        link.valid = valid_reg;
        link.value = value_reg;
        link.gt    = valid_reg && (value_reg > cmd.key);
        link.eq    = valid_reg && (value_reg == cmd.key);
        le         = valid_reg && (value_reg <= cmd.key);
        // insert boundary, or first of a run of equal values
        mark       = cmd.is_del ? (link.eq && !prev_link.eq) : (!link.gt && prev_link.gt);
    end

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (cmd.ins_en && !link.gt) begin
            value_next = prev_link.gt ? cmd.key : prev_link.value;
            valid_next = valid_reg | prev_link.valid;
        end else if (cmd.del_en && le) begin
            value_next = next_link.value;
            valid_next = next_link.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

// ===== design/sorted_list_insert_delete.sv =====
// Sorted list insert/delete, top level: request register, row of
// sli_cell storage cells, position encoder and result register; uses sli_pkg
//
// Keeps up to CAPACITY signed 32-bit values in descending order.
// Input channel (s_*): req_type 0 inserts item_value ahead of the first
// stored value less than or equal to it; req_type 1 removes the first stored
// value equal to item_value. Every request beat yields exactly one result
// beat on the m_* channel: status, position from the head, and new count.
// A request is held in the request register, its result in the result
// register. Throughput: one request per cycle while m_ready is high, set
// by the single compare-and-shift step that all cells make in parallel.
// The request register is refilled in the same cycle its request is
// applied, so s_ready stays high while the result register drains.
// When m_ready is low the result is held, the held request waits and
// s_ready falls until the result beat is taken.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// request or result; no clearing pass is needed.
`timescale 1ns / 1ps

module sorted_list_insert_delete import sli_pkg::*; #(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic signed [VALUE_W-1:0] s_item_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic [POS_W-1:0]          m_position,
    output logic [COUNT_W-1:0]        m_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                      pend_reg;
    logic                      pend_next;
    logic                      req_reg;
    logic signed [VALUE_W-1:0] key_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic [POS_W-1:0]          pos_reg;
    logic [POS_W-1:0]          pos_next;
    logic [COUNT_W-1:0]        cnt_out_reg;

    logic                      fire;
    logic                      s_beat;
    logic                      full;
    logic                      empty;
    logic                      found;
    logic [POS_W-1:0]          pos_hit;
    sli_cmd_t                  cmd;
    sli_link_t                 cell_link [CAPACITY];
    logic [CAPACITY-1:0]       mark;
    logic [CAPACITY-1:0]       eq_vec;

    assign fire    = pend_reg && (!m_valid_reg || m_ready);
    assign s_ready = !pend_reg || fire;
    assign s_beat  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign found   = |eq_vec;

    assign cmd.key    = key_reg;
    assign cmd.is_del = (req_reg == REQ_DELETE);
    assign cmd.ins_en = fire && (req_reg == REQ_INSERT) && !full;
    assign cmd.del_en = fire && (req_reg == REQ_DELETE) && found;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        sli_link_t prev_l;
        sli_link_t next_l;
        if (g == 0) begin : g_head
            assign prev_l = HEAD_LINK;
        end else begin : g_mid_prev
            assign prev_l = cell_link[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign next_l = TAIL_LINK;
        end else begin : g_mid_next
            assign next_l = cell_link[g+1];
        end
        sli_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .prev_link (prev_l),
            .next_link (next_l),
            .link      (cell_link[g]),
            .mark      (mark[g])
        );
        assign eq_vec[g] = cell_link[g].eq;
    end

    // one-hot mark to index, low bits only
    always_comb begin
        pos_hit = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (mark[i]) begin
                pos_hit = pos_hit | POS_W'(i);
            end
        end
    end

    always_comb begin
        status_next = status_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        if (fire) begin
            if (req_reg == REQ_INSERT) begin
                if (full) begin
                    status_next = ST_FULL;
                    pos_next    = '0;
                end else begin
                    status_next = ST_INSERTED;
                    pos_next    = pos_hit;
                    count_next  = count_reg + CNT_W'(1);
                end
            end else if (empty) begin
                status_next = ST_EMPTY;
                pos_next    = '0;
            end else if (found) begin
                status_next = ST_DELETED;
                pos_next    = pos_hit;
                count_next  = count_reg - CNT_W'(1);
            end else begin
                status_next = ST_NOT_FOUND;
                pos_next    = '0;
            end
        end
    end

    always_comb begin
        pend_next = pend_reg;
        if (s_beat) begin
            pend_next = 1'b1;
        end else if (fire) begin
            pend_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            req_reg <= s_req_type;
            key_reg <= s_item_value;
        end
        if (fire) begin
            status_reg  <= status_next;
            pos_reg     <= pos_next;
            cnt_out_reg <= COUNT_W'(count_next);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_position    = pos_reg;
    assign m_entry_count = cnt_out_reg;

endmodule

// ===== design/sli_checker.sv =====
// port checker for the sorted list insert/delete block, bound to the top level
// uses sli_pkg and sorted_list_insert_delete_macros.svh
`timescale 1ns / 1ps
`include "sorted_list_insert_delete_macros.svh"

module sli_checker import sli_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [STATUS_W-1:0]       m_status,
    input logic [POS_W-1:0]          m_position,
    input logic [COUNT_W-1:0]        m_entry_count
);

    logic [STATUS_W+POS_W+COUNT_W-1:0] res_bits;
    logic                              empty_beat;
    logic                              miss_beat;

    assign res_bits   = {m_status, m_position, m_entry_count};
    assign empty_beat = m_valid && (m_status == ST_EMPTY);
    assign miss_beat  = m_valid && (m_status == ST_NOT_FOUND || m_status == ST_FULL);

    // stalled result beat holds
    `SLI_ASSERT_NXT(a_res_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(res_bits))

    `SLI_ASSERT_IMP(a_status_code, aclk, aresetn, m_valid, m_status <= ST_FULL)

    `SLI_ASSERT_IMP(a_empty_beat, aclk, aresetn, empty_beat, {m_entry_count, m_position} == '0)

    `SLI_ASSERT_IMP(a_miss_pos, aclk, aresetn, miss_beat, m_position == '0)

endmodule

bind sorted_list_insert_delete sli_checker u_sli_checker (.*);
